>>> src/dense_layer_inference_top_defines.svh
// Assertion macros used by the checker file.
`ifndef DENSE_LAYER_INFERENCE_TOP_DEFINES_SVH
`define DENSE_LAYER_INFERENCE_TOP_DEFINES_SVH

// Same-cycle implication, reset disables the check.
`define DLI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dli check failed");

// Next-cycle implication, reset disables the check.
`define DLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dli check failed");

`endif

>>> src/dli_pkg.sv
package dli_pkg;

	localparam int MAX_INPUTS  = 64;
	localparam int MAX_OUTPUTS = 64;
	localparam int FRAC_BITS   = 12;
	localparam int VEC_LIMIT   = 64;

	localparam int IN_W  = $clog2(MAX_INPUTS);
	localparam int OUT_W = $clog2(MAX_OUTPUTS);
	localparam int CNT_W = 7;
	localparam int VAL_W = 16;
	localparam int ACC_W = 48;
	localparam int W_AW  = $clog2(MAX_INPUTS * MAX_OUTPUTS);

	localparam int ROM_SIZE  = 1024;
	localparam int ROM_ZERO  = 512;
	localparam int ROM_AW    = $clog2(ROM_SIZE);
	localparam int ROM_SHIFT = 2 * FRAC_BITS - 6;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] KIND_WEIGHT = 2'd0;
	localparam logic [1:0] KIND_BIAS   = 2'd1;
	localparam logic [1:0] KIND_INPUT  = 2'd2;

	localparam logic [1:0] ACT_RELU    = 2'd0;
	localparam logic [1:0] ACT_SIGMOID = 2'd1;
	localparam logic [1:0] ACT_TANH    = 2'd2;

	localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
	localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd1;
	localparam logic [1:0] CFG_ACT_MODE     = 2'd2;

	typedef struct packed {
		logic [1:0]              kind;
		logic [5:0]              in_index;
		logic [5:0]              out_index;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [5:0]              neuron_index;
		logic signed [VAL_W-1:0] activated;
		logic                    last;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_WEIGHT,
		OP_BIAS,
		OP_INPUT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t                 op;
		logic                    is_final;
		logic [5:0]              in_index;
		logic [5:0]              out_index;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] input_count;
		logic [CNT_W-1:0] output_count;
		logic [1:0]       act_mode;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [ROM_AW:0]   addr;
		logic [VAL_W-1:0]  data;
	} rom_wr_t;

	typedef enum logic [2:0] {
		BLD_PICK,
		BLD_DIV,
		BLD_WR_POS,
		BLD_WR_NEG,
		BLD_MUL_A,
		BLD_MUL_B,
		BLD_MUL_C,
		BLD_DONE
	} bld_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DRAIN
	} back_state_t;

	// Zero acts as one, large counts cap at the store limit.
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n, input int lim);
		logic [CNT_W-1:0] r;
		r = n;
		if (r == '0) r = CNT_W'(1);
		if (int'(r) > lim) r = CNT_W'(lim);
		if (int'(r) > VEC_LIMIT) r = CNT_W'(VEC_LIMIT);
		return r;
	endfunction

endpackage

>>> src/dli_queue.sv
module dli_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dli_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output dli_pkg::cmd_t pop_data,
	output logic          empty
);
	import dli_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> src/dli_front.sv
module dli_front (
	input  logic              in_valid,
	input  dli_pkg::in_item_t in_data,
	output logic              in_stall,
	input  logic              init_done,
	input  logic              q_full,
	input  dli_pkg::cfg_t     cfg,
	output logic              push,
	output dli_pkg::cmd_t     push_data
);
	import dli_pkg::*;

	logic [CNT_W-1:0] nin;
	logic             known;

	assign nin      = clamp_count(cfg.input_count, MAX_INPUTS);
	assign in_stall = !init_done || q_full;

	always_comb begin
		known          = 1'b1;
		push_data.op   = OP_INPUT;
		unique case (in_data.kind)
			KIND_WEIGHT: push_data.op = OP_WEIGHT;
			KIND_BIAS:   push_data.op = OP_BIAS;
			KIND_INPUT:  push_data.op = OP_INPUT;
			default:     known = 1'b0;
		endcase
		// Flag the element that closes the vector.
		push_data.is_final  = (in_data.kind == KIND_INPUT) &&
			(in_data.in_index == IN_W'(nin - 1'b1));
		push_data.in_index  = in_data.in_index;
		push_data.out_index = in_data.out_index;
		push_data.value     = in_data.value;
	end

	// Drop unknown kinds here.
	assign push = in_valid && !in_stall && known;

endmodule

>>> src/dli_rom_build.sv
module dli_rom_build (
	input  logic             clk,
	input  logic             arst_n,
	output dli_pkg::rom_wr_t rom_wr,
	output logic             done
);
	import dli_pkg::*;

	localparam int E_W = 33;
	localparam int D_W = 34;
	localparam int Q_W = FRAC_BITS + 1;
	localparam int N_W = D_W + Q_W - 1;
	localparam int K_W = ROM_AW + 1;
	localparam logic [31:0] EXP_STEP = 32'd4228380000;

	bld_state_t       state_q, state_d;
	logic [K_W-1:0]   k_q;
	logic [E_W-1:0]   e_q;
	logic [47:0]      p_lo_q;
	logic [48:0]      p_hi_q;
	logic [N_W-1:0]   rem_q;
	logic [N_W-1:0]   dsh_q;
	logic [Q_W-1:0]   quo_q;
	logic [3:0]       bit_q;
	logic             job_tanh_q;
	logic             sig_done_q;
	logic             tanh_done_q;

	logic             need_sig;
	logic             need_tanh;
	logic [D_W-1:0]   den;
	logic [K_W-1:0]   m;
	logic [65:0]      e_sum;

	assign need_sig  = (k_q <= K_W'(ROM_ZERO)) && !sig_done_q;
	assign need_tanh = !k_q[0] && !tanh_done_q;
	assign den       = (D_W'(1) << 32) + D_W'(e_q);
	assign m         = job_tanh_q ? (k_q >> 1) : k_q;
	assign e_sum     = {1'b0, p_hi_q, 16'b0} + 66'(p_lo_q) + (66'(1) << 31);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BLD_PICK: begin
				if (need_sig || need_tanh) state_d = BLD_DIV;
				else if (k_q == K_W'(2 * ROM_ZERO)) state_d = BLD_DONE;
				else state_d = BLD_MUL_A;
			end
			BLD_DIV:    if (bit_q == '0) state_d = BLD_WR_POS;
			BLD_WR_POS: state_d = BLD_WR_NEG;
			BLD_WR_NEG: state_d = BLD_PICK;
			BLD_MUL_A:  state_d = BLD_MUL_B;
			BLD_MUL_B:  state_d = BLD_MUL_C;
			BLD_MUL_C:  state_d = BLD_PICK;
			BLD_DONE:   state_d = BLD_DONE;
			default:    state_d = BLD_PICK;
		endcase
	end

	always_comb begin
		rom_wr = '0;
		done   = (state_q == BLD_DONE);
		unique case (state_q)
			BLD_WR_POS: begin
				rom_wr.en   = (m <= K_W'(ROM_ZERO - 1));
				rom_wr.addr = {job_tanh_q, ROM_AW'(K_W'(ROM_ZERO) + m)};
				rom_wr.data = VAL_W'(quo_q);
			end
			BLD_WR_NEG: begin
				// Mirror: sigmoid(-x) = 1 - sigmoid(x), tanh(-x) = -tanh(x).
				rom_wr.en   = (m != '0);
				rom_wr.addr = {job_tanh_q, ROM_AW'(K_W'(ROM_ZERO) - m)};
				rom_wr.data = job_tanh_q ? (VAL_W'(0) - VAL_W'(quo_q)) :
					((VAL_W'(1) << FRAC_BITS) - VAL_W'(quo_q));
			end
			default: rom_wr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BLD_PICK;
			k_q         <= '0;
			e_q         <= E_W'(1) << 32;
			job_tanh_q  <= 1'b0;
			sig_done_q  <= 1'b0;
			tanh_done_q <= 1'b0;
			bit_q       <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				BLD_PICK: begin
					bit_q      <= 4'(Q_W - 1);
					job_tanh_q <= !need_sig;
				end
				BLD_DIV:    bit_q <= bit_q - 1'b1;
				BLD_WR_NEG: begin
					if (job_tanh_q) tanh_done_q <= 1'b1;
					else sig_done_q <= 1'b1;
				end
				BLD_MUL_C: begin
					e_q         <= e_sum[64:32];
					k_q         <= k_q + 1'b1;
					sig_done_q  <= 1'b0;
					tanh_done_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Restoring divider, one quotient bit per cycle, and the exp recurrence.
	always_ff @(posedge clk) begin
		unique case (state_q)
			BLD_PICK: begin
				if (need_sig) rem_q <= (N_W'(1) << (FRAC_BITS + 32)) + N_W'(den >> 1);
				else rem_q <= (N_W'((E_W'(1) << 32) - e_q) << FRAC_BITS) + N_W'(den >> 1);
				dsh_q <= N_W'(den) << (Q_W - 1);
				quo_q <= '0;
			end
			BLD_DIV: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[Q_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[Q_W-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			BLD_MUL_A: p_lo_q <= 48'(e_q[15:0]) * 48'(EXP_STEP);
			BLD_MUL_B: p_hi_q <= 49'(e_q[32:16]) * 49'(EXP_STEP);
			default: ;
		endcase
	end

endmodule

>>> src/dli_back.sv
module dli_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  dli_pkg::cmd_t      q_data,
	output logic               q_pop,
	input  dli_pkg::cfg_t      cfg,
	input  dli_pkg::rom_wr_t   rom_wr,
	output logic               out_valid,
	input  logic               out_stall,
	output dli_pkg::out_item_t out_data
);
	import dli_pkg::*;

	localparam int T_W = ACC_W - ROM_SHIFT;
	localparam logic signed [T_W-1:0] T_LO = T_W'(-ROM_ZERO);
	localparam logic signed [T_W-1:0] T_HI = T_W'(ROM_ZERO - 1);
	localparam logic signed [ACC_W-1:0] RELU_TOP = ACC_W'(1) <<< (FRAC_BITS + VAL_W - 1);

	logic signed [VAL_W-1:0] w_mem [MAX_INPUTS * MAX_OUTPUTS];
	logic signed [VAL_W-1:0] b_mem [MAX_OUTPUTS];
	logic signed [VAL_W-1:0] x_mem [MAX_INPUTS];
	logic [VAL_W-1:0]        rom_mem [2 * ROM_SIZE];

	back_state_t      state_q, state_d;
	logic [IN_W-1:0]  i_q;
	logic [OUT_W-1:0] j_q;
	logic [CNT_W-1:0] nin, nout;
	logic             last_i, last_j;
	logic             adv, issue, start, pipe_busy;

	logic                    v_s1, first_s1, lasti_s1, lastj_s1;
	logic [OUT_W-1:0]        j_s1;
	logic signed [VAL_W-1:0] w_s1, x_s1, b_s1;

	logic                    v_s2, first_s2, lasti_s2, lastj_s2;
	logic [OUT_W-1:0]        j_s2;
	logic signed [2*VAL_W-1:0] prod_s2;
	logic signed [VAL_W-1:0] b_s2;

	logic signed [ACC_W-1:0] acc_q, nacc;
	logic                    v_s3, lastj_s3;
	logic [OUT_W-1:0]        j_s3;
	logic signed [ACC_W-1:0] sum_s3;

	logic signed [T_W-1:0]   t;
	logic [ROM_AW-1:0]       idx;
	logic [VAL_W-1:0]        relu;

	logic                    v_s4, lastj_s4, use_rom_s4;
	logic [OUT_W-1:0]        j_s4;
	logic [ROM_AW:0]         rom_addr_s4;
	logic [VAL_W-1:0]        relu_s4;

	logic                    v_s5, lastj_s5, use_rom_s5;
	logic [OUT_W-1:0]        j_s5;
	logic [VAL_W-1:0]        relu_s5, rom_s5;

	logic                    out_valid_q;
	out_item_t               out_q;

	assign nin       = clamp_count(cfg.input_count, MAX_INPUTS);
	assign nout      = clamp_count(cfg.output_count, MAX_OUTPUTS);
	assign last_i    = (i_q == IN_W'(nin - 1'b1));
	assign last_j    = (j_q == OUT_W'(nout - 1'b1));
	assign adv       = !out_valid_q || !out_stall;
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign start     = q_pop && (q_data.op == OP_INPUT) && q_data.is_final;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (start) state_d = BK_RUN;
			BK_RUN:   if (issue && last_i && last_j) state_d = BK_DRAIN;
			BK_DRAIN: if (!pipe_busy) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == BK_IDLE) && !q_empty;
		issue = (state_q == BK_RUN) && adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				i_q <= '0;
				j_q <= '0;
			end else if (issue) begin
				if (last_i) begin
					i_q <= '0;
					j_q <= j_q + 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	// Store writes from the queue and table writes from the builder.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			unique case (q_data.op)
				OP_WEIGHT: begin
					if (int'(q_data.in_index) < MAX_INPUTS && int'(q_data.out_index) < MAX_OUTPUTS)
						w_mem[W_AW'(q_data.in_index * MAX_OUTPUTS + q_data.out_index)] <=
							q_data.value;
				end
				OP_BIAS: begin
					if (int'(q_data.out_index) < MAX_OUTPUTS)
						b_mem[OUT_W'(q_data.out_index)] <= q_data.value;
				end
				OP_INPUT: begin
					if (int'(q_data.in_index) < MAX_INPUTS)
						x_mem[IN_W'(q_data.in_index)] <= q_data.value;
				end
				default: ;
			endcase
		end
		if (rom_wr.en) rom_mem[rom_wr.addr] <= rom_wr.data;
	end

	// Registered store reads, held while the output stalls.
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1   <= w_mem[W_AW'(i_q * MAX_OUTPUTS + j_q)];
			x_s1   <= x_mem[i_q];
			b_s1   <= b_mem[j_q];
			rom_s5 <= rom_mem[rom_addr_s4];
		end
	end

	assign nacc = (first_s2 ? (ACC_W'(b_s2) <<< FRAC_BITS) : acc_q) + ACC_W'(prod_s2);

	always_comb begin
		t = T_W'(sum_s3 >>> ROM_SHIFT);
		if (t < T_LO) idx = '0;
		else if (t > T_HI) idx = ROM_AW'(ROM_SIZE - 1);
		else idx = ROM_AW'(t + T_W'(ROM_ZERO));
		if (sum_s3 <= 0) relu = '0;
		else if (sum_s3 >= RELU_TOP) relu = VAL_W'((1 << (VAL_W - 1)) - 1);
		else relu = sum_s3[FRAC_BITS +: VAL_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2 && lasti_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1 <= (i_q == '0);
			lasti_s1 <= last_i;
			lastj_s1 <= last_j;
			j_s1     <= j_q;

			prod_s2  <= x_s1 * w_s1;
			b_s2     <= b_s1;
			first_s2 <= first_s1;
			lasti_s2 <= lasti_s1;
			lastj_s2 <= lastj_s1;
			j_s2     <= j_s1;

			if (v_s2) acc_q <= nacc;
			sum_s3   <= nacc;
			lastj_s3 <= lastj_s2;
			j_s3     <= j_s2;

			use_rom_s4  <= (cfg.act_mode == ACT_SIGMOID) || (cfg.act_mode == ACT_TANH);
			rom_addr_s4 <= {cfg.act_mode == ACT_TANH, idx};
			relu_s4     <= relu;
			lastj_s4    <= lastj_s3;
			j_s4        <= j_s3;

			use_rom_s5 <= use_rom_s4;
			relu_s5    <= relu_s4;
			lastj_s5   <= lastj_s4;
			j_s5       <= j_s4;

			out_q.neuron_index <= 6'(j_s5);
			out_q.activated    <= use_rom_s5 ? rom_s5 : relu_s5;
			out_q.last         <= lastj_s5;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> src/dense_layer_inference_top.sv
// Dense layer with ReLU, sigmoid or tanh on signed Q4.12 data and 48-bit sums. After reset the
// block builds its sigmoid and tanh tables (one divide per entry pair plus the exponential
// recurrence) and holds in_stall high meanwhile; config writes are taken throughout. Weight, bias
// and non-final input requests pass through the front end into the back end; a four-entry queue
// lets the front keep accepting while the back is busy. The final input element starts a pass
// over output_count * input_count weights through the single multiply-accumulate (one weight
// read per cycle from the weight memory while the output does not stall), and each result then
// waits in an output register for out_stall to drop.
module dense_layer_inference_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  dli_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output dli_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);
	import dli_pkg::*;

	cfg_t    cfg_q;
	logic    init_done;
	rom_wr_t rom_wr;
	logic    push, pop, q_full, q_empty;
	cmd_t    push_data, pop_data;

	// Always take a config request; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_count  <= CNT_W'(64);
			cfg_q.output_count <= CNT_W'(64);
			cfg_q.act_mode     <= ACT_RELU;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_INPUT_COUNT:  cfg_q.input_count  <= cfg_data;
				CFG_OUTPUT_COUNT: cfg_q.output_count <= cfg_data;
				CFG_ACT_MODE:     cfg_q.act_mode     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Build the activation tables once after reset.
	dli_rom_build u_rom_build (
		.clk    (clk),
		.arst_n (arst_n),
		.rom_wr (rom_wr),
		.done   (init_done)
	);

	// Classify requests and flag the vector-closing element.
	dli_front u_front (
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.init_done (init_done),
		.q_full    (q_full),
		.cfg       (cfg_q),
		.push      (push),
		.push_data (push_data)
	);

	dli_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	// Execute stores and forward passes in queue order.
	dli_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.q_pop     (pop),
		.cfg       (cfg_q),
		.rom_wr    (rom_wr),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

>>> src/dli_checker.sv
`include "dense_layer_inference_top_defines.svh"

module dli_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input dli_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input dli_pkg::out_item_t out_data
);
	import dli_pkg::*;

	logic [5:0] exp_q;

	// Track the neuron index the next result must carry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (out_valid && !out_stall) begin
			exp_q <= out_data.last ? 6'd0 : (out_data.neuron_index + 6'd1);
		end
	end

	`DLI_ASSERT_NEXT(a_in_stable, clk, arst_n, in_valid && in_stall, in_valid && $stable(in_data))
	`DLI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`DLI_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_data))
	`DLI_ASSERT_NOW(a_index_order, clk, arst_n, out_valid, out_data.neuron_index == exp_q)
	`DLI_ASSERT_NOW(a_last_at_top, clk, arst_n, out_valid && (out_data.neuron_index == 6'd63), out_data.last)

endmodule

bind dense_layer_inference_top dli_checker u_checker (.*);
